// ===== rtl/isr_pkg.sv =====
package isr_pkg;

    localparam int MAX_RECORDS_DEF = 1024;
    localparam int PAGE_SIZE_DEF   = 8;

    // request codes
    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_SEARCH = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // status codes
    localparam logic [2:0] ST_STORED    = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_CLEARED   = 3'd4;

    // one stored record
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] price;
        logic [63:0] title_low;
        logic [15:0] title_high;
    } rec_t;

endpackage

// ===== rtl/isr_ram.sv =====
module isr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/indexed_sequential_search_top.sv =====
// Indexed sequential search store. Raise start with a request while busy is
// low; the request is taken at that edge. Every request except the unused
// code 3 answers with exactly one word, shown for one cycle with done high;
// the receiver cannot stall, so it must capture the word when done is seen.
// Append and clear never raise busy: the word appears on the next cycle,
// so a new request may be issued while the answer is shown. A search of a
// non-empty store holds busy high while it walks the page index, one index
// RAM read per cycle, then any chosen page, one record RAM read per cycle.
// A search of an empty store answers like an append and never raises
// busy. Records are expected in ascending key order; the index holds each
// page's first key, partial last page included.
module indexed_sequential_search_top
    import isr_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF,
    parameter int PAGE_SIZE   = PAGE_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic signed [31:0] rec_key,
    input  logic signed [31:0] rec_price,
    input  logic [63:0] title_low,
    input  logic [15:0] title_high,
    output logic        done,
    output logic [2:0]  status,
    output logic signed [31:0] found_key,
    output logic signed [31:0] found_price,
    output logic [63:0] found_title_low,
    output logic [15:0] found_title_high
);

    localparam int INDEX_DEPTH = (MAX_RECORDS + PAGE_SIZE - 1) / PAGE_SIZE;
    localparam int AW  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int IAW = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;
    localparam int CW  = $clog2(MAX_RECORDS + 1);   // record count
    localparam int PCW = $clog2(INDEX_DEPTH + 1);   // page count
    localparam int FW  = $clog2(PAGE_SIZE + 1);     // slot within a page
    localparam int BW  = $clog2(MAX_RECORDS + PAGE_SIZE + 1); // page base

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_IDX   = 2'd1;  // index entry data valid
    localparam logic [1:0] S_PG_RD = 2'd2;  // first record read issued
    localparam logic [1:0] S_PG    = 2'd3;  // record data valid

    logic [1:0]     state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [PCW-1:0] pages_reg, pages_next;
    logic [FW-1:0]  fill_reg, fill_next;    // count mod PAGE_SIZE

    // search context
    logic [PCW-1:0] i_reg, i_next;
    logic [BW-1:0]  base_reg, base_next;
    logic [BW-1:0]  sel_base_reg, sel_base_next;
    logic           have_page_reg, have_page_next;
    logic           sel_last_reg, sel_last_next;
    logic [FW-1:0]  j_reg, j_next;
    logic [FW-1:0]  pg_cnt_reg, pg_cnt_next;
    logic [31:0]    query_reg, query_next;

    // result word
    logic        done_reg, done_next;
    logic [2:0]  status_reg, status_next;
    rec_t        res_reg, res_next;

    // memories
    logic           rec_we;
    logic [AW-1:0]  rec_addr;
    rec_t           rec_wdata, rec_rdata;
    logic           idx_we;
    logic [IAW-1:0] idx_addr;
    logic [31:0]    idx_rdata;

    logic           accept;
    logic [PCW-1:0] i_inc;
    logic [FW-1:0]  j_inc;
    logic [BW-1:0]  rd_next_addr;
    logic           key_le;

    assign accept       = start && (state_reg == S_IDLE);
    assign i_inc        = i_reg + PCW'(1);
    assign j_inc        = j_reg + FW'(1);
    assign rd_next_addr = sel_base_reg + BW'(j_inc);
    assign key_le       = $signed(idx_rdata) <= $signed(query_reg);

    assign rec_wdata = '{key: rec_key, price: rec_price,
                         title_low: title_low, title_high: title_high};

    isr_ram #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (MAX_RECORDS)
    ) u_rec_ram (
        .clk   (clk),
        .we    (rec_we),
        .addr  (rec_addr),
        .wdata (rec_wdata),
        .rdata (rec_rdata)
    );

    isr_ram #(
        .WIDTH (32),
        .DEPTH (INDEX_DEPTH)
    ) u_idx_ram (
        .clk   (clk),
        .we    (idx_we),
        .addr  (idx_addr),
        .wdata (rec_key),
        .rdata (idx_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pages_next     = pages_reg;
        fill_next      = fill_reg;
        i_next         = i_reg;
        base_next      = base_reg;
        sel_base_next  = sel_base_reg;
        have_page_next = have_page_reg;
        sel_last_next  = sel_last_reg;
        j_next         = j_reg;
        pg_cnt_next    = pg_cnt_reg;
        query_next     = query_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        res_next       = res_reg;

        rec_we   = 1'b0;
        rec_addr = count_reg[AW-1:0];
        idx_we   = 1'b0;
        idx_addr = pages_reg[IAW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // default answer: echo key, zero payload
                    res_next = '{key: rec_key, price: '0,
                                 title_low: '0, title_high: '0};
                    query_next = rec_key;
                    case (req_type)
                        REQ_APPEND:
                        begin
                            done_next = 1'b1;
                            if (count_reg == CW'(MAX_RECORDS))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next = ST_STORED;
                                rec_we      = 1'b1;
                                count_next  = count_reg + CW'(1);
                                if (fill_reg == '0)
                                begin
                                    idx_we     = 1'b1;  // new page: index its first key
                                    pages_next = pages_reg + PCW'(1);
                                end
                                if (fill_reg == FW'(PAGE_SIZE - 1))
                                begin
                                    fill_next = '0;
                                end
                                else
                                begin
                                    fill_next = fill_reg + FW'(1);
                                end
                            end
                        end
                        REQ_SEARCH:
                        begin
                            if (pages_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                idx_addr       = '0;
                                i_next         = '0;
                                base_next      = '0;
                                have_page_next = 1'b0;
                                state_next     = S_IDX;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_CLEARED;
                            count_next  = '0;
                            pages_next  = '0;
                            fill_next   = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_IDX:
            begin
                idx_addr = i_inc[IAW-1:0];
                if (key_le)
                begin
                    have_page_next = 1'b1;
                    sel_base_next  = base_reg;
                    sel_last_next  = (i_inc == pages_reg);
                    if (i_inc == pages_reg)
                    begin
                        state_next = S_PG_RD;
                    end
                    else
                    begin
                        i_next    = i_inc;
                        base_next = base_reg + BW'(PAGE_SIZE);
                    end
                end
                else if (have_page_reg)
                begin
                    state_next = S_PG_RD;
                end
                else
                begin
                    // query below the first page
                    done_next   = 1'b1;
                    status_next = ST_NOT_FOUND;
                    state_next  = S_IDLE;
                end
            end

            S_PG_RD:
            begin
                rec_addr = sel_base_reg[AW-1:0];
                j_next   = '0;
                if (sel_last_reg && (fill_reg != '0))
                begin
                    pg_cnt_next = fill_reg;   // partial last page
                end
                else
                begin
                    pg_cnt_next = FW'(PAGE_SIZE);
                end
                state_next = S_PG;
            end

            S_PG:
            begin
                rec_addr = rd_next_addr[AW-1:0];
                if (rec_rdata.key == query_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_FOUND;
                    res_next    = rec_rdata;
                    state_next  = S_IDLE;
                end
                else if (j_inc < pg_cnt_reg)
                begin
                    j_next = j_inc;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOT_FOUND;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pages_reg     <= '0;
            fill_reg      <= '0;
            done_reg      <= 1'b0;
            have_page_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pages_reg     <= pages_next;
            fill_reg      <= fill_next;
            done_reg      <= done_next;
            have_page_reg <= have_page_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        base_reg     <= base_next;
        sel_base_reg <= sel_base_next;
        sel_last_reg <= sel_last_next;
        j_reg        <= j_next;
        pg_cnt_reg   <= pg_cnt_next;
        query_reg    <= query_next;
        status_reg   <= status_next;
        res_reg      <= res_next;
    end

    assign busy             = (state_reg != S_IDLE);
    assign done             = done_reg;
    assign status           = status_reg;
    assign found_key        = res_reg.key;
    assign found_price      = res_reg.price;
    assign found_title_low  = res_reg.title_low;
    assign found_title_high = res_reg.title_high;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb
    import isr_pkg::*;
();

    // sizing of the block under test (package defaults)
    localparam int MAX_REC   = MAX_RECORDS_DEF;
    localparam int PG        = PAGE_SIZE_DEF;
    localparam int IDX_DEPTH = (MAX_REC + PG - 1) / PG;

    // code 3 is not a request: the block takes it and answers nothing
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // run length: roughly 1900 words
    localparam int TARGET_WORDS = 1900;
    localparam int TAIL_CYCLES  = 160;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int CALM_TAIL    = 150;

    localparam longint KEY_MAX = (longint'(1) <<< 31) - 1;
    localparam longint KEY_MIN = -(longint'(1) <<< 31);

    // one request on its way to the block
    typedef struct {
        logic [1:0]         req;
        logic signed [31:0] key;
        logic signed [31:0] price;
        logic [63:0]        tlo;
        logic [15:0]        thi;
        bit                 drain;   // hold off until every answer is back
        bit                 gap_ok;  // sender may idle after this word
    } request_t;

    // one answer word
    typedef struct {
        logic [2:0]         status;
        logic signed [31:0] key;
        logic signed [31:0] price;
        logic [63:0]        tlo;
        logic [15:0]        thi;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         req_type = REQ_APPEND;
    logic signed [31:0] rec_key = '0;
    logic signed [31:0] rec_price = '0;
    logic [63:0]        title_low = '0;
    logic [15:0]        title_high = '0;
    logic               done;
    logic [2:0]         status;
    logic signed [31:0] found_key;
    logic signed [31:0] found_price;
    logic [63:0]        found_title_low;
    logic [15:0]        found_title_high;

    always #4 clk = ~clk;

    indexed_sequential_search_top i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .req_type         (req_type),
        .rec_key          (rec_key),
        .rec_price        (rec_price),
        .title_low        (title_low),
        .title_high       (title_high),
        .done             (done),
        .status           (status),
        .found_key        (found_key),
        .found_price      (found_price),
        .found_title_low  (found_title_low),
        .found_title_high (found_title_high)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the store, the page index and the record count.
    // ------------------------------------------------------------------
    rec_t               shelf [MAX_REC];
    logic signed [31:0] page_first [IDX_DEPTH];
    int                 stored_cnt = 0;

    // Apply one accepted request to the shadow store and work out the word
    // it answers with. Returns 0 when the request produces no word.
    function automatic bit lookup_answer(input logic [1:0] rq,
                                         input logic signed [31:0] k,
                                         input logic signed [31:0] p,
                                         input logic [63:0] tl,
                                         input logic [15:0] th,
                                         output answer_t w);
        int n;
        int pages;
        int pg_hit;
        int span;
        int base;
        int a;
        bit answers;
        bit hit;
        w.status = ST_NOT_FOUND;
        w.key    = k;
        w.price  = '0;
        w.tlo    = '0;
        w.thi    = '0;
        answers  = 1'b1;
        n        = stored_cnt;
        case (rq)
            REQ_APPEND:
            begin
                if (n >= MAX_REC)
                    w.status = ST_FULL;
                else
                begin
                    shelf[n].key        = k;
                    shelf[n].price      = p;
                    shelf[n].title_low  = tl;
                    shelf[n].title_high = th;
                    // first record of a page goes into the index
                    if (n % PG == 0)
                        page_first[n / PG] = k;
                    stored_cnt = n + 1;
                    w.status   = ST_STORED;
                end
            end
            REQ_SEARCH:
            begin
                pages = (n + PG - 1) / PG;
                if (pages > IDX_DEPTH)
                    pages = IDX_DEPTH;
                // walk the index while first keys do not exceed the query
                pg_hit = 0;
                while (pg_hit < pages && page_first[pg_hit] <= k)
                    pg_hit++;
                if (pg_hit != 0)
                begin
                    // last page holds only the remainder
                    if (pg_hit < pages || n % PG == 0)
                        span = PG;
                    else
                        span = n % PG;
                    base = (pg_hit - 1) * PG;
                    hit  = 1'b0;
                    for (int j = 0; j < span && !hit; j++)
                    begin
                        a = base + j;
                        if (a < n && shelf[a].key == k)
                        begin
                            hit      = 1'b1;
                            w.status = ST_FOUND;
                            w.key    = shelf[a].key;
                            w.price  = shelf[a].price;
                            w.tlo    = shelf[a].title_low;
                            w.thi    = shelf[a].title_high;
                        end
                    end
                end
            end
            REQ_CLEAR:
            begin
                stored_cnt = 0;
                w.status   = ST_CLEARED;
            end
            default:
                answers = 1'b0;
        endcase
        return answers;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus store and bookkeeping.
    // words_issued is owned by the driver and words_seen by the monitor;
    // both move by nonblocking assignment, so each side reads the other's
    // count as it stood before the edge.
    // ------------------------------------------------------------------
    request_t request_q[$];
    answer_t  answer_q[$];
    int       words_issued = 0;
    int       words_seen = 0;
    int       fail_cnt = 0;
    int       idle_left = 0;
    bit       cur_gap_ok = 1'b0;
    int       cycle_cnt = 0;

    // ------------------------------------------------------------------
    // Driver: a word is taken at an edge where start is high and busy low.
    // Start is held while busy; gaps only open after a word is taken.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        request_t nxt;
        answer_t  w;
        bit       taken;
        bit       has_word;
        bit       drained;
        if (!rst_n)
        begin
            start        <= 1'b0;
            idle_left    <= 0;
            words_issued <= 0;
        end
        else
        begin
            taken    = start && !busy;
            has_word = 1'b0;
            if (taken)
            begin
                has_word = lookup_answer(req_type, rec_key, rec_price, title_low,
                                         title_high, w);
                if (has_word)
                begin
                    answer_q.push_back(w);
                    words_issued <= words_issued + 1;
                end
            end
            // nothing outstanding, counting the word taken at this edge
            drained = (words_issued == words_seen) && !has_word;

            if (start && !taken)
            begin
                // held until the block drops busy
            end
            else if (taken && cur_gap_ok && $urandom_range(0, 2) == 0)
            begin
                // idle burst: start drops, then idle_left counts down
                start     <= 1'b0;
                idle_left <= $urandom_range(0, 4);
            end
            else if (idle_left != 0)
            begin
                start     <= 1'b0;
                idle_left <= idle_left - 1;
            end
            else if (request_q.size() != 0 && (!request_q[0].drain || drained))
            begin
                nxt = request_q.pop_front();
                req_type   <= nxt.req;
                rec_key    <= nxt.key;
                rec_price  <= nxt.price;
                title_low  <= nxt.tlo;
                title_high <= nxt.thi;
                cur_gap_ok <= nxt.gap_ok;
                start      <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every word shown with done is checked against the oldest
    // expected answer. The receiver cannot stall, so nothing to drive here.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : check_answers
        answer_t w;
        if (!rst_n)
            words_seen <= 0;
        else if (done)
        begin
            if (words_seen == words_issued)
            begin
                $error("unexpected answer word: status %0d, key %0d", status, found_key);
                fail_cnt++;
            end
            else
            begin
                w = answer_q.pop_front();
                words_seen <= words_seen + 1;
                if (status !== w.status)
                begin
                    $error("status: expected %0d, got %0d", w.status, status);
                    fail_cnt++;
                end
                if (found_key !== w.key)
                begin
                    $error("found_key: expected %0d, got %0d", w.key, found_key);
                    fail_cnt++;
                end
                if (found_price !== w.price)
                begin
                    $error("found_price: expected %0d, got %0d", w.price, found_price);
                    fail_cnt++;
                end
                if (found_title_low !== w.tlo)
                begin
                    $error("found_title_low: expected %h, got %h", w.tlo, found_title_low);
                    fail_cnt++;
                end
                if (found_title_high !== w.thi)
                begin
                    $error("found_title_high: expected %h, got %h", w.thi,
                           found_title_high);
                    fail_cnt++;
                end
            end
        end
    end

    // hard stop if the block hangs
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    bit     gaps_on = 1'b1;
    int     words_planned = 0;
    longint keys_added[$];

    task automatic queue_request(input logic [1:0] rq, input longint k,
                                 input logic signed [31:0] p, input logic [63:0] tl,
                                 input logic [15:0] th, input bit drain);
        request_t r;
        r.req    = rq;
        r.key    = k[31:0];
        r.price  = p;
        r.tlo    = tl;
        r.thi    = th;
        r.drain  = drain;
        r.gap_ok = gaps_on;
        request_q.push_back(r);
        if (rq != REQ_UNUSED)
            words_planned++;
    endtask

    function automatic longint rand_key();
        return longint'($signed($urandom));
    endfunction

    // titles: mostly random, sometimes all zeros or all ones
    function automatic logic [63:0] rand_tlo();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [15:0] rand_thi();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return 16'($urandom_range(0, 16'hffff));
    endfunction

    task automatic append_record(input longint k);
        queue_request(REQ_APPEND, k, $urandom, rand_tlo(), rand_thi(), 1'b0);
        keys_added.push_back(k);
    endtask

    task automatic search_key(input longint k);
        queue_request(REQ_SEARCH, k, $urandom, {$urandom, $urandom}, 16'($urandom), 1'b0);
    endtask

    // query key: mostly stored keys, else neighbors, out-of-range and noise
    function automatic longint pick_probe();
        int sel;
        int n;
        longint lo;
        longint hi;
        sel = $urandom_range(0, 9);
        n   = keys_added.size();
        if (n == 0 || sel == 0)
            return rand_key();
        lo = keys_added[0];
        hi = keys_added[0];
        foreach (keys_added[i])
        begin
            if (keys_added[i] < lo)
                lo = keys_added[i];
            if (keys_added[i] > hi)
                hi = keys_added[i];
        end
        case (sel)
            1: return lo - 1;
            2: return hi + 1;
            3: return $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
            4: return keys_added[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
            default: return keys_added[$urandom_range(0, n - 1)];
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin : run_test
        int     seq_no;
        int     len;
        int     mode;
        longint cursor;
        longint k;

        // directed: empty store, extremes, partial last page, below first page
        search_key(0);
        queue_request(REQ_UNUSED, rand_key(), $urandom, '1, '1, 1'b0);
        queue_request(REQ_APPEND, KEY_MIN, 32'sh8000_0000, '0, '0, 1'b0);
        queue_request(REQ_APPEND, -5, 32'sh7fff_ffff, '1, '1, 1'b0);
        for (int i = 0; i < 6; i++)
            queue_request(REQ_APPEND, longint'(i), $urandom, {$urandom, $urandom},
                          16'($urandom), 1'b0);
        queue_request(REQ_APPEND, 100, -1, 64'h0123_4567_89ab_cdef, 16'h5a5a, 1'b0);
        queue_request(REQ_APPEND, KEY_MAX, 0, 64'hfedc_ba98_7654_3210, 16'ha5a5, 1'b0);
        search_key(KEY_MIN);
        search_key(KEY_MAX);
        search_key(50);      // lands in first page, no match
        search_key(100);     // partial last page
        search_key(5);
        // clear waits for every answer to be back
        queue_request(REQ_CLEAR, -1, $urandom, '1, '1, 1'b1);
        queue_request(REQ_APPEND, 10, 7, '1, '0, 1'b0);
        search_key(5);       // below the first page
        search_key(10);
        queue_request(REQ_UNUSED, KEY_MAX, -1, '0, '0, 1'b0);
        search_key(KEY_MAX);

        // random: clear, then ascending appends mixed with searches
        seq_no = 0;
        while (words_planned < TARGET_WORDS)
        begin
            gaps_on = ($urandom_range(0, 9) < 7);
            queue_request(REQ_CLEAR, rand_key(), $urandom, rand_tlo(), rand_thi(),
                          ($urandom_range(0, 1) == 1));
            keys_added.delete();
            // one run fills the store past its capacity
            if (seq_no == 2)
                len = MAX_REC + 6;
            else if ($urandom_range(0, 7) == 0)
                len = $urandom_range(41, 150);
            else
                len = $urandom_range(1, 40);
            mode = $urandom_range(0, 3);
            if (mode == 0)
                cursor = KEY_MIN + $urandom_range(0, 5);
            else if (mode == 1)
                cursor = KEY_MAX - longint'(len) * 150;
            else
                cursor = rand_key();
            if (seq_no == 2)
                cursor = rand_key() / 4;
            for (int i = 0; i < len; i++)
            begin
                // a few out-of-order keys as noise
                if ($urandom_range(0, 19) == 0)
                    k = rand_key();
                else
                begin
                    k = cursor;
                    if ($urandom_range(0, 9) != 0)
                        cursor = cursor + $urandom_range(1, 300);
                    if (cursor > KEY_MAX)
                        cursor = KEY_MAX;
                end
                append_record(k);
                if ($urandom_range(0, (len > 200) ? 7 : 3) == 0)
                    search_key(pick_probe());
                if ($urandom_range(0, 99) == 0)
                    queue_request(REQ_UNUSED, rand_key(), $urandom, rand_tlo(),
                                  rand_thi(), 1'b0);
            end
            repeat ($urandom_range(3, 12))
                search_key(pick_probe());
            seq_no++;
        end

        // no idling toward the end of the run
        for (int i = request_q.size() - CALM_TAIL; i < request_q.size(); i++)
            if (i >= 0)
                request_q[i].gap_ok = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || start || words_seen != words_issued)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_cnt == 0 && words_seen == words_issued)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/isr_pkg.sv
rtl/isr_ram.sv
rtl/indexed_sequential_search_top.sv
tb/tb.sv
